// ----- sv/pts_pkg.sv -----
// Shared types and constants for the priority task scheduler.
package pts_pkg;

  localparam logic [2:0] CMD_CREATE    = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_TERMINATE = 3'd2;
  localparam logic [2:0] CMD_SUSPEND   = 3'd3;
  localparam logic [2:0] CMD_RESUME    = 3'd4;
  localparam logic [2:0] CMD_SLEEP     = 3'd5;
  localparam logic [2:0] CMD_YIELD     = 3'd6;
  localparam logic [2:0] CMD_TICK      = 3'd7;

  localparam logic [2:0] ST_DEAD      = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_RUNNING   = 3'd2;
  localparam logic [2:0] ST_SUSPENDED = 3'd3;
  localparam logic [2:0] ST_SLEEPING  = 3'd4;

  localparam logic [2:0] ERR_OK          = 3'd0;
  localparam logic [2:0] ERR_FULL        = 3'd1;
  localparam logic [2:0] ERR_NOT_FOUND   = 3'd2;
  localparam logic [2:0] ERR_NOT_SUSP_OK = 3'd3;
  localparam logic [2:0] ERR_NOT_SUSP    = 3'd4;
  localparam logic [2:0] ERR_NO_RUN      = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new command and clear the scan state
    logic scan_step; // examine one slot in the current scan
    logic scan_disp; // scan is a dispatch (otherwise a lookup/tick pass)
    logic commit;    // apply the command's effect
    logic pick;      // apply the dispatch result
  } pts_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_disp; // committed command asks for a dispatch
  } pts_sts_t;

endpackage

// ----- sv/pts_ctrl.sv -----
// Controller state machine for the priority task scheduler.
module pts_ctrl
  import pts_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  pts_sts_t sts,
  output pts_ctl_t ctl,
  output logic     busy,
  output logic     out_valid
);

  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_COMIT = 3'd2;
  localparam logic [2:0] S_DSCAN = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(SLOTS - 1)) state_nxt = S_COMIT;
      end
      S_COMIT: begin
        ctl.commit = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = sts.need_disp ? S_DSCAN : S_OUT;
      end
      S_DSCAN: begin
        ctl.scan_step = 1'b1;
        ctl.scan_disp = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(SLOTS - 1)) state_nxt = S_PICK;
      end
      S_PICK: begin
        ctl.pick  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

// ----- sv/pts_dpath.sv -----
// Datapath of the priority task scheduler: task table, scan unit and result.
module pts_dpath
  import pts_pkg::*;
#(
  parameter int SLOTS        = 8,
  parameter int LOWEST_LEVEL = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pts_ctl_t    ctl,
  output pts_sts_t    sts,
  input  logic [2:0]  cmd_in,
  input  logic [3:0]  pri_in,
  input  logic [15:0] tid_in,
  input  logic [14:0] ticks_in,
  output logic [2:0]  error_code,
  output logic        dispatched,
  output logic [2:0]  running_slot,
  output logic [15:0] running_id,
  output logic        idle,
  output logic [15:0] created_id
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = $clog2(LOWEST_LEVEL + 2);
  localparam int LW = $clog2(SLOTS + 1);

  logic [2:0]  status_r [SLOTS];
  logic [2:0]  saved_r  [SLOTS];
  logic [3:0]  prio_r   [SLOTS];
  logic [15:0] id_r     [SLOTS];
  logic [15:0] sleep_r  [SLOTS];

  logic [IW-1:0] last_r, run_r;
  logic [LW-1:0] live_r;
  logic [15:0]   idc_r;
  logic          idle_r, started_r;

  logic [2:0]  cmd_r;
  logic [3:0]  pri_r;
  logic [15:0] tid_r;
  logic [14:0] ticks_r;

  // Scan state: pointer, lookup results, dispatch best.
  logic [IW-1:0] ptr_r;
  logic          dead_hit_r, id_hit_r;
  logic [IW-1:0] dead_idx_r, id_idx_r;
  logic          any_r;
  logic [PW-1:0] best_r;
  logic [IW-1:0] found_r;
  logic          disp_r;
  logic [2:0]    err_r;
  logic [15:0]   created_r;

  logic [IW-1:0] ptr_inc, last_inc;
  assign ptr_inc  = (ptr_r == IW'(SLOTS - 1)) ? '0 : ptr_r + 1'b1;
  assign last_inc = (last_r == IW'(SLOTS - 1)) ? '0 : last_r + 1'b1;

  logic [2:0] ks, kv;
  assign ks = status_r[id_idx_r];
  assign kv = saved_r[id_idx_r];

  // Whether the command being committed asks for a dispatch pass; it is read
  // by the controller in the commit cycle, so it is decoded from the state
  // as it stands before the commit.
  logic need_c;
  always_comb begin
    need_c = 1'b0;
    unique case (cmd_r)
      CMD_START:     need_c = !started_r && live_r != '0;
      CMD_TERMINATE: need_c = !idle_r;
      CMD_SLEEP:     need_c = !idle_r;
      CMD_YIELD:     need_c = !idle_r;
      CMD_SUSPEND:   need_c = id_hit_r && ks != ST_DEAD && ks != ST_SUSPENDED &&
                              !idle_r && id_idx_r == run_r;
      CMD_TICK:      need_c = started_r && idle_r;
      default:       need_c = 1'b0;
    endcase
  end

  assign sts.need_disp = need_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        status_r[i] <= ST_DEAD;
        saved_r[i]  <= ST_DEAD;
        prio_r[i]   <= '0;
        id_r[i]     <= '0;
        sleep_r[i]  <= '0;
      end
      last_r <= '0; run_r <= '0; live_r <= '0; idc_r <= '0;
      idle_r <= 1'b1; started_r <= 1'b0;
      disp_r <= 1'b0; err_r <= ERR_OK; created_r <= '0;
    end else begin
      if (ctl.load) begin
        cmd_r <= cmd_in; pri_r <= pri_in; tid_r <= tid_in; ticks_r <= ticks_in;
        ptr_r <= '0; dead_hit_r <= 1'b0; id_hit_r <= 1'b0;
        dead_idx_r <= '0; id_idx_r <= '0;
        disp_r <= 1'b0; err_r <= ERR_OK; created_r <= '0;
      end
      if (ctl.scan_step && !ctl.scan_disp) begin
        // Lookup pass, which also carries the tick countdown of one slot.
        if (!dead_hit_r && status_r[ptr_r] == ST_DEAD) begin
          dead_hit_r <= 1'b1; dead_idx_r <= ptr_r;
        end
        if (!id_hit_r && tid_r != '0 && id_r[ptr_r] == tid_r) begin
          id_hit_r <= 1'b1; id_idx_r <= ptr_r;
        end
        if (cmd_r == CMD_TICK && (status_r[ptr_r] == ST_SLEEPING ||
            (status_r[ptr_r] == ST_SUSPENDED && saved_r[ptr_r] == ST_SLEEPING))) begin
          if (sleep_r[ptr_r] <= 16'd1) begin
            sleep_r[ptr_r] <= '0;
            if (status_r[ptr_r] == ST_SLEEPING) status_r[ptr_r] <= ST_READY;
            else saved_r[ptr_r] <= ST_READY;
          end else begin
            sleep_r[ptr_r] <= sleep_r[ptr_r] - 1'b1;
          end
        end
        ptr_r <= ptr_inc;
      end
      if (ctl.commit) begin
        ptr_r  <= last_inc;
        any_r  <= 1'b0;
        best_r <= PW'(LOWEST_LEVEL + 1);
        found_r <= '0;
        unique case (cmd_r)
          CMD_CREATE: begin
            if (!dead_hit_r || live_r >= LW'(SLOTS)) begin
              err_r <= ERR_FULL;
            end else begin
              idc_r <= (idc_r == 16'hFFFF) ? 16'd1 : idc_r + 1'b1;
              created_r <= (idc_r == 16'hFFFF) ? 16'd1 : idc_r + 1'b1;
              id_r[dead_idx_r] <= (idc_r == 16'hFFFF) ? 16'd1 : idc_r + 1'b1;
              status_r[dead_idx_r] <= ST_READY;
              saved_r[dead_idx_r]  <= ST_DEAD;
              prio_r[dead_idx_r]   <= (32'(pri_r) > LOWEST_LEVEL) ?
                                      4'(LOWEST_LEVEL) : pri_r;
              sleep_r[dead_idx_r]  <= '0;
              live_r <= live_r + 1'b1;
            end
          end
          CMD_START: begin
            if (!started_r && live_r != '0) begin
              started_r <= 1'b1;
            end
          end
          CMD_TERMINATE: begin
            if (idle_r) err_r <= ERR_NO_RUN;
            else begin
              status_r[run_r] <= ST_DEAD;
              if (live_r != '0) live_r <= live_r - 1'b1;
            end
          end
          CMD_SUSPEND: begin
            if (!id_hit_r) err_r <= ERR_NOT_FOUND;
            else if (ks == ST_DEAD || ks == ST_SUSPENDED) err_r <= ERR_NOT_SUSP_OK;
            else begin
              saved_r[id_idx_r]  <= (ks == ST_RUNNING) ? ST_READY : ks;
              status_r[id_idx_r] <= ST_SUSPENDED;
            end
          end
          CMD_RESUME: begin
            if (!id_hit_r) err_r <= ERR_NOT_FOUND;
            else if (ks != ST_SUSPENDED) err_r <= ERR_NOT_SUSP;
            else begin
              status_r[id_idx_r] <= (kv == ST_SLEEPING) ? ST_SLEEPING : ST_READY;
              saved_r[id_idx_r]  <= ST_SUSPENDED;
            end
          end
          CMD_SLEEP: begin
            if (idle_r) err_r <= ERR_NO_RUN;
            else begin
              status_r[run_r] <= ST_SLEEPING;
              sleep_r[run_r]  <= {1'b0, ticks_r};
            end
          end
          CMD_YIELD: begin
            if (idle_r) err_r <= ERR_NO_RUN;
            else begin
              status_r[run_r] <= ST_READY;
            end
          end
          CMD_TICK: ;
          default: ;
        endcase
      end
      if (ctl.scan_step && ctl.scan_disp) begin
        if (status_r[ptr_r] == ST_READY && PW'(prio_r[ptr_r]) < best_r) begin
          best_r <= PW'(prio_r[ptr_r]); found_r <= ptr_r; any_r <= 1'b1;
        end
        ptr_r <= ptr_inc;
      end
      if (ctl.pick) begin
        disp_r <= any_r;
        if (any_r) begin
          last_r <= found_r; run_r <= found_r;
          status_r[found_r] <= ST_RUNNING; idle_r <= 1'b0;
        end else begin
          idle_r <= 1'b1;
        end
      end
    end
  end

  assign error_code   = err_r;
  assign dispatched   = disp_r;
  assign idle         = idle_r;
  assign running_slot = idle_r ? 3'd0 : 3'(run_r);
  assign running_id   = idle_r ? 16'd0 : id_r[run_r];
  assign created_id   = created_r;

endmodule

// ----- sv/priority_task_scheduler_unit.sv -----
// Top level of the priority task scheduler.
//
//   Channel  Direction  Payload
//   in_*     input      command, priority_req, target_id, sleep_ticks
//   out_*    output     error_code, dispatched, running_slot, running_id,
//                       idle, created_id
//
// One transaction is handled at a time. A command runs a lookup pass and a
// commit step, then, when it needs a dispatch, a dispatch pass and a pick
// step, before its result is offered; the block returns to idle before the
// next transaction is accepted. A lookup pass walks the slots one per cycle;
// a dispatch pass walks them again from the slot after the last one
// dispatched. in_tready is high only while the block is idle, and a result
// holds until out_tready takes it. Reset is synchronous, active low.
module priority_task_scheduler_unit
  import pts_pkg::*;
#(
  parameter int SLOTS        = 8,
  parameter int LOWEST_LEVEL = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], priority_req[6:3], target_id[22:7], sleep_ticks[37:23]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // error_code[2:0], dispatched[3], running_slot[6:4], running_id[22:7],
  // idle[23], created_id[39:24]
  output logic [39:0] out_tdata
);

  pts_ctl_t ctl;
  pts_sts_t sts;
  logic     busy;
  logic [2:0]  err, rslot;
  logic        disp, idl;
  logic [15:0] rid, cid;

  assign in_tready = !busy;

  pts_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk, .rst_n,
    .in_fire  (in_tvalid && in_tready),
    .out_fire (out_tvalid && out_tready),
    .sts, .ctl, .busy,
    .out_valid(out_tvalid)
  );

  pts_dpath #(.SLOTS(SLOTS), .LOWEST_LEVEL(LOWEST_LEVEL)) u_dpath (
    .clk, .rst_n, .ctl, .sts,
    .cmd_in(in_tdata[2:0]), .pri_in(in_tdata[6:3]),
    .tid_in(in_tdata[22:7]), .ticks_in(in_tdata[37:23]),
    .error_code(err), .dispatched(disp), .running_slot(rslot),
    .running_id(rid), .idle(idl), .created_id(cid)
  );

  assign out_tdata = {cid, idl, rid, rslot, disp, err};

endmodule

// ----- tb/sv/priority_task_scheduler_unit_checker.sv -----
// Checker for the priority task scheduler: predicts each result and compares it.
module priority_task_scheduler_unit_checker
  import pts_pkg::*;
#(
  parameter int SLOTS        = 8,
  parameter int LOWEST_LEVEL = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Listed from the highest bits down, matching the result bus layout.
  typedef struct packed {
    logic [15:0] created_id;
    logic        idle;
    logic [15:0] running_id;
    logic [2:0]  running_slot;
    logic        dispatched;
    logic [2:0]  error_code;
  } sched_result_t;

  logic [2:0]  task_state [SLOTS];
  logic [2:0]  held_state [SLOTS];
  logic [3:0]  task_prio  [SLOTS];
  logic [15:0] task_ident [SLOTS];
  logic [15:0] ticks_left [SLOTS];
  int          prev_pick, run_slot, live_tasks;
  logic [15:0] next_ident;
  logic        sched_idle, sched_started;
  sched_result_t expected_results[$];

  assign pending_count = expected_results.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic bit dispatch_next();
    int j, best, found;
    bit any;
    j = prev_pick;
    best = LOWEST_LEVEL + 1;
    found = 0;
    any = 0;
    for (int n = 0; n < SLOTS; n++) begin
      j = (j + 1) % SLOTS;
      if (task_state[j] == ST_READY && task_prio[j] < best) begin
        best = task_prio[j];
        found = j;
        any = 1;
      end
    end
    if (any) begin
      prev_pick = found;
      run_slot = found;
      task_state[found] = ST_RUNNING;
      sched_idle = 0;
    end else begin
      sched_idle = 1;
    end
    return any;
  endfunction

  function automatic int lookup_task(input logic [15:0] id);
    if (id == 0) return -1;
    for (int i = 0; i < SLOTS; i++)
      if (task_ident[i] == id) return i;
    return -1;
  endfunction

  function automatic sched_result_t apply_command(input logic [39:0] d);
    sched_result_t r;
    logic [2:0]  cmd;
    int          pri, k, i;
    logic [15:0] tid;
    logic [14:0] nticks;
    cmd = d[2:0];
    pri = d[6:3];
    tid = d[22:7];
    nticks = d[37:23];
    r = '0;
    r.error_code = ERR_OK;
    case (cmd)
      CMD_CREATE: begin
        for (i = 0; i < SLOTS; i++)
          if (task_state[i] == ST_DEAD) break;
        if (live_tasks >= SLOTS || i >= SLOTS) begin
          r.error_code = ERR_FULL;
        end else begin
          next_ident = (next_ident == 16'hFFFF) ? 16'd1 : next_ident + 16'd1;
          if (pri > LOWEST_LEVEL) pri = LOWEST_LEVEL;
          task_state[i] = ST_READY;
          held_state[i] = ST_DEAD;
          task_prio[i] = 4'(pri);
          task_ident[i] = next_ident;
          ticks_left[i] = 0;
          live_tasks++;
          r.created_id = next_ident;
        end
      end
      CMD_START: begin
        if (!sched_started && live_tasks > 0) begin
          sched_started = 1;
          r.dispatched = dispatch_next();
        end
      end
      CMD_TERMINATE: begin
        if (sched_idle) begin
          r.error_code = ERR_NO_RUN;
        end else begin
          task_state[run_slot] = ST_DEAD;
          if (live_tasks > 0) live_tasks--;
          r.dispatched = dispatch_next();
        end
      end
      CMD_SUSPEND: begin
        k = lookup_task(tid);
        if (k < 0) begin
          r.error_code = ERR_NOT_FOUND;
        end else if (task_state[k] == ST_DEAD || task_state[k] == ST_SUSPENDED) begin
          r.error_code = ERR_NOT_SUSP_OK;
        end else begin
          held_state[k] = (task_state[k] == ST_RUNNING) ? ST_READY : task_state[k];
          task_state[k] = ST_SUSPENDED;
          if (!sched_idle && k == run_slot) r.dispatched = dispatch_next();
        end
      end
      CMD_RESUME: begin
        k = lookup_task(tid);
        if (k < 0) begin
          r.error_code = ERR_NOT_FOUND;
        end else if (task_state[k] != ST_SUSPENDED) begin
          r.error_code = ERR_NOT_SUSP;
        end else begin
          task_state[k] = (held_state[k] == ST_SLEEPING) ? ST_SLEEPING : ST_READY;
          held_state[k] = ST_SUSPENDED;
        end
      end
      CMD_SLEEP: begin
        if (sched_idle) begin
          r.error_code = ERR_NO_RUN;
        end else begin
          task_state[run_slot] = ST_SLEEPING;
          ticks_left[run_slot] = nticks;
          r.dispatched = dispatch_next();
        end
      end
      CMD_YIELD: begin
        if (sched_idle) begin
          r.error_code = ERR_NO_RUN;
        end else begin
          task_state[run_slot] = ST_READY;
          r.dispatched = dispatch_next();
        end
      end
      default: begin
        // Sleepers count down even while suspended.
        for (i = 0; i < SLOTS; i++) begin
          if (task_state[i] == ST_SLEEPING ||
              (task_state[i] == ST_SUSPENDED && held_state[i] == ST_SLEEPING)) begin
            if (ticks_left[i] <= 1) begin
              ticks_left[i] = 0;
              if (task_state[i] == ST_SLEEPING) task_state[i] = ST_READY;
              else held_state[i] = ST_READY;
            end else begin
              ticks_left[i] = ticks_left[i] - 16'd1;
            end
          end
        end
        if (sched_started && sched_idle) r.dispatched = dispatch_next();
      end
    endcase
    r.idle = sched_idle;
    r.running_slot = sched_idle ? 3'd0 : run_slot[2:0];
    r.running_id = sched_idle ? 16'd0 : task_ident[run_slot];
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        task_state[i] = ST_DEAD;
        held_state[i] = ST_DEAD;
        task_prio[i] = 0;
        task_ident[i] = 0;
        ticks_left[i] = 0;
      end
      prev_pick = 0;
      run_slot = 0;
      live_tasks = 0;
      next_ident = 0;
      sched_idle = 1;
      sched_started = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(apply_command(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected", $time);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.error_code != want.error_code)
            report_mismatch("error_code", got.error_code, want.error_code);
          if (got.dispatched != want.dispatched)
            report_mismatch("dispatched", got.dispatched, want.dispatched);
          if (got.running_slot != want.running_slot)
            report_mismatch("running_slot", got.running_slot, want.running_slot);
          if (got.running_id != want.running_id)
            report_mismatch("running_id", got.running_id, want.running_id);
          if (got.idle != want.idle)
            report_mismatch("idle", got.idle, want.idle);
          if (got.created_id != want.created_id)
            report_mismatch("created_id", got.created_id, want.created_id);
        end
      end
    end
  end
endmodule

// ----- tb/sv/priority_task_scheduler_unit_tb.sv -----
// Testbench top for the priority task scheduler: stimulus, reset and verdict.
module priority_task_scheduler_unit_tb;
  import pts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_COMMANDS = 1200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // command[2:0], priority_req[6:3], target_id[22:7], sleep_ticks[37:23]
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // error_code[2:0], dispatched[3], running_slot[6:4], running_id[22:7],
  // idle[23], created_id[39:24]
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending_count;
  int          quiet_cycles;
  bit          stimulus_done;
  // Ids handed out so far, so that suspend and resume mostly hit real tasks.
  logic [15:0] issued_ids[$];

  priority_task_scheduler_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  priority_task_scheduler_unit_checker checker_inst (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sends one command transaction after a random gap. A gap of zero keeps
  // tvalid high straight into the next transaction.
  task automatic send_command(input logic [2:0] cmd, input logic [3:0] pri,
                              input logic [15:0] tid, input logic [14:0] nticks);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, nticks, tid, pri, cmd};
    do @(posedge clk); while (!in_tready);
    // Capture the id the block will give, unknown here; track via output below.
  endtask

  // The receiving side stalls for a random number of cycles before each result.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (out_tdata[39:24] != 0) issued_ids.push_back(out_tdata[39:24]);
    end
  end

  // Picks a target id: mostly one that was issued, sometimes anything.
  function automatic logic [15:0] pick_target();
    if (issued_ids.size() > 0 && $urandom_range(0, 9) < 8)
      return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
    return $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom());
  endfunction

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (stimulus_done && pending_count == 0) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("priority_task_scheduler_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int r;
    logic [2:0] cmd;
    stimulus_done = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: errors before anything exists, then filling the table,
    // priority extremes, a tick before start, and each command.
    send_command(CMD_YIELD, 4'd0, 16'd0, 15'd0);
    send_command(CMD_TERMINATE, 4'd0, 16'd0, 15'd0);
    send_command(CMD_SLEEP, 4'd0, 16'd0, 15'd5);
    send_command(CMD_START, 4'd0, 16'd0, 15'd0);
    send_command(CMD_SUSPEND, 4'd0, 16'd0, 15'd0);
    send_command(CMD_RESUME, 4'd0, 16'hFFFF, 15'd0);
    for (int i = 0; i < 9; i++)
      send_command(CMD_CREATE, (i % 2) ? 4'd15 : 4'd0, 16'd0, 15'h7FFF);
    send_command(CMD_TICK, 4'd0, 16'd0, 15'd0);
    send_command(CMD_START, 4'd0, 16'd0, 15'd0);
    send_command(CMD_START, 4'd0, 16'd0, 15'd0);
    send_command(CMD_SLEEP, 4'd0, 16'd0, 15'd0);
    send_command(CMD_SUSPEND, 4'd0, 16'd2, 15'd0);
    send_command(CMD_SUSPEND, 4'd0, 16'd2, 15'd0);
    send_command(CMD_TICK, 4'd0, 16'd0, 15'd0);
    send_command(CMD_RESUME, 4'd0, 16'd2, 15'd0);
    send_command(CMD_RESUME, 4'd0, 16'd2, 15'd0);
    send_command(CMD_YIELD, 4'd0, 16'd0, 15'd0);
    send_command(CMD_TERMINATE, 4'd0, 16'd0, 15'd0);

    // Random part: mostly meaningful commands on live ids, with short sleeps
    // so sleepers wake, and occasional long sleeps and wild fields.
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 14)      cmd = CMD_CREATE;
      else if (r < 17) cmd = CMD_START;
      else if (r < 27) cmd = CMD_TERMINATE;
      else if (r < 39) cmd = CMD_SUSPEND;
      else if (r < 51) cmd = CMD_RESUME;
      else if (r < 61) cmd = CMD_SLEEP;
      else if (r < 73) cmd = CMD_YIELD;
      else             cmd = CMD_TICK;
      send_command(cmd, 4'($urandom()), pick_target(),
                   ($urandom_range(0, 19) == 0) ? 15'($urandom()) : 15'($urandom_range(0, 4)));
    end
    in_tvalid <= 1'b0;
    stimulus_done = 1;

    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("priority_task_scheduler_unit: match");
    end else begin
      $display("priority_task_scheduler_unit: mismatch");
    end
    $finish;
  end
endmodule
